@@ hdl/cpa_pkg.sv @@
// Package for the contiguous page allocator: sizes, status codes, beat types.
// No dependencies.
package cpa_pkg;

    localparam int NUM_PAGES  = 256;
    localparam int MAX_OWNERS = 16;
    localparam int PW = $clog2(NUM_PAGES);      // page index width
    localparam int CW = PW + 1;                 // page count width
    localparam int SW = $clog2(MAX_OWNERS);     // slot index width

    localparam logic [2:0] ST_ALLOC    = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_RELOC    = 3'd5;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_END   = 1'b1;

    localparam logic [0:0] REG_PAGES_IN_USE = 1'b0;

    typedef struct packed {
        logic [CW-1:0] run_length;
        logic [PW-1:0] old_first_page;
        logic [PW-1:0] first_page;
        logic [15:0]   owner_out;
        logic [2:0]    status;
    } res_t;

endpackage

@@ hdl/contiguous_page_allocator_compacting_unit.sv @@
// Top level of the contiguous page allocator with compaction.
// Depends on cpa_pkg.
//
//  channel   | dir | beat contents
//  s_axis    | in  | tdata {page_count, owner_id, req_type}, bit 0 up
//  m_axis    | out | tdata {free_total, run_length, old_first_page, first_page,
//            |     |        owner_out, status}, tlast = last
//  apb       | in  | reg 0 pages_in_use at 0x0
//
// Sequence: a scan of the slots, then the freed run cleared page by page (end), or a bitmap
// pass over the managed pages and the allocated run set page by page (start), then the beat.
// Compaction picks each placed owner by a scan of the slots, closes with one more pick round,
// clears each moved run's old pages, then sets its new ones, and makes a second bitmap pass.
// Reset clears bitmap and slots and sets the free count to NUM_PAGES at once (flip-flops).
// s_axis_tready is low while a request is in work; a waiting output beat stalls
// the sequencer only when a new beat must be issued.
module contiguous_page_allocator_compacting_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_type[0], owner_id[16:1], page_count[25:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status[2:0] owner_out[18:3] first_page[26:19]
                                        // old_first_page[34:27] run_length[43:35]
                                        // free_total[52:44]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int PW = cpa_pkg::PW;
    localparam int CW = cpa_pkg::CW;
    localparam int SW = cpa_pkg::SW;
    localparam int NP = cpa_pkg::NUM_PAGES;
    localparam int MO = cpa_pkg::MAX_OWNERS;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SLOT   = 11'b00000000010,  // end: look up owner / start: find free slot
        S_CLR    = 11'b00000000100,  // clear a run page by page
        S_FIND   = 11'b00000001000,  // first-fit scan
        S_PICK   = 11'b00000010000,  // compaction: pick next lowest start
        S_MOVEC  = 11'b00000100000,  // clear old run
        S_MOVES  = 11'b00001000000,  // set new run
        S_SET    = 11'b00010000000,  // set allocated run
        S_EMIT   = 11'b00100000000,  // push result beat
        S_FIND2  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [NP-1:0]  used_reg;
    logic [CW-1:0]  free_reg;
    logic [CW-1:0]  piu_reg;
    logic [MO-1:0]  valid_reg;
    logic [15:0]    sown_reg [MO];
    logic [PW-1:0]  sstart_reg [MO];
    logic [CW-1:0]  slen_reg [MO];

    logic           req_reg;
    logic [15:0]    own_reg;
    logic [CW-1:0]  n_reg;
    logic [SW-1:0]  slot_reg;      // scan index / chosen slot
    logic [CW-1:0]  pg_reg;        // page cursor
    logic [CW-1:0]  cnt_reg;       // pages left / run length
    logic [CW-1:0]  run_reg;
    logic [CW-1:0]  dst_reg;       // compaction cursor
    logic           comp_reg;      // compaction done
    logic [MO-1:0]  done_reg;      // slots already placed by compaction
    logic           best_ok_reg;
    logic [SW-1:0]  best_reg;
    logic           after_reg;     // after emit: 0 finish, 1 continue compaction
    cpa_pkg::res_t  res_reg;
    logic           ov_reg, ol_reg;
    logic [55:0]    od_reg;

    logic [CW-1:0] managed;
    assign managed = (piu_reg > CW'(NP)) ? CW'(NP) : piu_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == cpa_pkg::REG_PAGES_IN_USE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cpa_pkg::REG_PAGES_IN_USE) ? {23'd0, piu_reg} : 32'd0;

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_wr;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    logic in_acc, out_free;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;

    logic [PW-1:0] pgi;
    assign pgi = pg_reg[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= s_axis_tdata[0];
            own_reg <= s_axis_tdata[16:1];
            n_reg   <= s_axis_tdata[25:17];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            free_reg  <= CW'(NP);
            piu_reg   <= CW'(NP);
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            // S_EMIT reloads the output register itself
            if (ov_reg && m_axis_tready && state_reg != S_EMIT)
                ov_reg <= 1'b0;
            if (cfg_wr)
            begin
                piu_reg   <= pwdata[CW-1:0];
                used_reg  <= '0;
                valid_reg <= '0;
                free_reg  <= (pwdata[CW-1:0] > CW'(NP)) ? CW'(NP) : pwdata[CW-1:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        slot_reg  <= '0;
                        state_reg <= S_SLOT;
                    end
                end
                S_SLOT:
                begin
                    if (req_reg == cpa_pkg::REQ_END)
                    begin
                        if (valid_reg[slot_reg] && sown_reg[slot_reg] == own_reg)
                        begin
                            valid_reg[slot_reg] <= 1'b0;
                            pg_reg  <= CW'(sstart_reg[slot_reg]);
                            cnt_reg <= slen_reg[slot_reg];
                            res_reg <= '{status: cpa_pkg::ST_FREED, owner_out: own_reg,
                                         first_page: sstart_reg[slot_reg],
                                         old_first_page: '0,
                                         run_length: slen_reg[slot_reg]};
                            state_reg <= S_CLR;
                        end
                        else if (slot_reg == SW'(MO - 1))
                        begin
                            res_reg <= '{status: cpa_pkg::ST_NOTFOUND, owner_out: own_reg,
                                         first_page: '0, old_first_page: '0,
                                         run_length: '0};
                            after_reg <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                        else
                            slot_reg <= slot_reg + 1'b1;
                    end
                    else if (n_reg == '0 || n_reg > free_reg)
                    begin
                        res_reg <= '{status: cpa_pkg::ST_NOSPACE, owner_out: own_reg,
                                     first_page: '0, old_first_page: '0, run_length: n_reg};
                        after_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else if (!valid_reg[slot_reg])
                    begin
                        pg_reg    <= '0;
                        run_reg   <= '0;
                        comp_reg  <= 1'b0;
                        state_reg <= S_FIND;
                    end
                    else if (slot_reg == SW'(MO - 1))
                    begin
                        res_reg <= '{status: cpa_pkg::ST_FULL, owner_out: own_reg,
                                     first_page: '0, old_first_page: '0, run_length: n_reg};
                        after_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                S_CLR:
                begin
                    if (cnt_reg == '0 || pg_reg >= CW'(NP))
                    begin
                        after_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (used_reg[pgi])
                        begin
                            used_reg[pgi] <= 1'b0;
                            free_reg <= free_reg + 1'b1;
                        end
                        pg_reg  <= pg_reg + 1'b1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_FIND, S_FIND2:
                begin
                    if (pg_reg >= managed)
                    begin
                        if (!comp_reg)
                        begin
                            comp_reg  <= 1'b1;
                            done_reg  <= '0;
                            dst_reg   <= '0;
                            cnt_reg   <= '0;      // pick scan index
                            best_ok_reg <= 1'b0;
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            res_reg <= '{status: cpa_pkg::ST_NOSPACE, owner_out: own_reg,
                                         first_page: '0, old_first_page: '0,
                                         run_length: n_reg};
                            after_reg <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                    end
                    else if (used_reg[pgi])
                    begin
                        run_reg <= '0;
                        pg_reg  <= pg_reg + 1'b1;
                    end
                    else if (run_reg + 1'b1 == n_reg)
                    begin
                        res_reg <= '{status: cpa_pkg::ST_ALLOC, owner_out: own_reg,
                                     first_page: PW'(pg_reg + 1'b1 - n_reg),
                                     old_first_page: '0, run_length: n_reg};
                        pg_reg  <= pg_reg + 1'b1 - n_reg;
                        cnt_reg <= n_reg;
                        state_reg <= S_SET;
                    end
                    else
                    begin
                        run_reg <= run_reg + 1'b1;
                        pg_reg  <= pg_reg + 1'b1;
                    end
                end
                S_PICK:
                begin
                    // one slot compared per cycle; lowest start, ties to lower index
                    if (valid_reg[cnt_reg[SW-1:0]] && !done_reg[cnt_reg[SW-1:0]]
                        && (!best_ok_reg
                            || sstart_reg[cnt_reg[SW-1:0]] < sstart_reg[best_reg]))
                    begin
                        best_ok_reg <= 1'b1;
                        best_reg    <= cnt_reg[SW-1:0];
                    end
                    if (cnt_reg == CW'(MO - 1))
                    begin
                        cnt_reg <= '0;
                        if (!(best_ok_reg || (valid_reg[SW'(MO - 1)]
                                              && !done_reg[SW'(MO - 1)])))
                        begin
                            pg_reg    <= '0;
                            run_reg   <= '0;
                            state_reg <= S_FIND2;
                        end
                        else
                            state_reg <= S_MOVEC;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_MOVEC:
                begin
                    // cnt_reg: pages stepped so far of best slot
                    if (cnt_reg == '0 && CW'(sstart_reg[best_reg]) == dst_reg)
                    begin
                        done_reg[best_reg] <= 1'b1;
                        dst_reg     <= dst_reg + slen_reg[best_reg];
                        best_ok_reg <= 1'b0;
                        state_reg   <= S_PICK;
                    end
                    else if (cnt_reg == slen_reg[best_reg]
                             || CW'(sstart_reg[best_reg]) + cnt_reg >= CW'(NP))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MOVES;
                    end
                    else
                    begin
                        if (used_reg[PW'(CW'(sstart_reg[best_reg]) + cnt_reg)])
                        begin
                            used_reg[PW'(CW'(sstart_reg[best_reg]) + cnt_reg)] <= 1'b0;
                            free_reg <= free_reg + 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MOVES:
                begin
                    if (cnt_reg == slen_reg[best_reg] || dst_reg + cnt_reg >= CW'(NP))
                    begin
                        res_reg <= '{status: cpa_pkg::ST_RELOC, owner_out: sown_reg[best_reg],
                                     first_page: dst_reg[PW-1:0],
                                     old_first_page: sstart_reg[best_reg],
                                     run_length: slen_reg[best_reg]};
                        sstart_reg[best_reg] <= dst_reg[PW-1:0];
                        done_reg[best_reg]   <= 1'b1;
                        dst_reg     <= dst_reg + slen_reg[best_reg];
                        best_ok_reg <= 1'b0;
                        cnt_reg     <= '0;
                        after_reg   <= 1'b1;
                        state_reg   <= S_EMIT;
                    end
                    else
                    begin
                        if (!used_reg[PW'(dst_reg + cnt_reg)])
                        begin
                            used_reg[PW'(dst_reg + cnt_reg)] <= 1'b1;
                            free_reg <= free_reg - 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SET:
                begin
                    if (cnt_reg == '0 || pg_reg >= CW'(NP))
                    begin
                        valid_reg[slot_reg]  <= 1'b1;
                        sown_reg[slot_reg]   <= own_reg;
                        sstart_reg[slot_reg] <= res_reg.first_page;
                        slen_reg[slot_reg]   <= n_reg;
                        after_reg <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        if (!used_reg[pgi])
                        begin
                            used_reg[pgi] <= 1'b1;
                            free_reg <= free_reg - 1'b1;
                        end
                        pg_reg  <= pg_reg + 1'b1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg <= 1'b1;
                        ol_reg <= !after_reg;
                        od_reg <= {3'd0, free_reg, res_reg};
                        state_reg <= after_reg ? S_PICK : S_DONE;
                    end
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CW'(NP)) else $error("free count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !m_axis_tready) |=> $stable(od_reg)) else $error("beat changed");

endmodule
